/* hw/rtl/ttce_pkg.sv */
package ttce_pkg;

    localparam int CHAR_W       = 8;
    localparam int COLOR_W      = 8;
    localparam int CELL_INDEX_W = 11;
    localparam int OUT_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CHAR_W-1:0]  CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0]  CH_FG      = 8'h46;
    localparam logic [CHAR_W-1:0]  CH_BG      = 8'h42;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'h0A;
    localparam logic [COLOR_W-1:0] COLOR_INIT = 8'h0F;

    // one cursor operation: a cell write, or a newline that only moves the cursor
    typedef struct packed {
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] color;
        logic               newline;
        logic               last;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        logic r;
        r = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66))
            || ((c >= 8'h41) && (c <= 8'h46));
        return r;
    endfunction

    function automatic logic [3:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        if ((c >= 8'h30) && (c <= 8'h39))
        begin
            d = c - 8'h30;
        end
        else if ((c >= 8'h61) && (c <= 8'h66))
        begin
            d = c - 8'h57;
        end
        else if ((c >= 8'h41) && (c <= 8'h46))
        begin
            d = c - 8'h37;
        end
        else
        begin
            d = '0;
        end
        return d[3:0];
    endfunction

endpackage

/* hw/rtl/text_terminal_with_color_escapes.sv */
// Text terminal writer: takes one character byte per transaction (tlast marks the end of a
// string) and produces cell writes {cell_index, glyph, cell_color} for a screen of
// SCREEN_ROWS x SCREEN_COLUMNS, with tlast on the final write caused by each character.
// "$F<hex>" and "$B<hex>" set the foreground or background nibble; a broken escape is
// written out as text. Newline moves the cursor without a write. The front end takes one
// character per cycle, while the 4-entry queue is not full, when it yields at most one cursor
// operation; a broken escape yields up to three and holds the input until all are issued, one
// per cycle. The back end retires one operation (one cell write or one newline) per cycle, a
// cell write only while the output is not stalled, so a steady stream of printable characters
// runs at one transaction per cycle on both sides, passing through the queue and output register.
module text_terminal_with_color_escapes #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ttce_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // end_of_string
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ttce_pkg::OUT_DATA_W-1:0]     m_tdata,   // [10:0] cell_index,
                                                           // [18:11] glyph,
                                                           // [26:19] cell_color, rest 0
    output logic                                m_tlast    // last_write
);

    ttce_pkg::q_status_t q_status;
    ttce_pkg::op_t       push_data, head;
    logic                push, pop;

    ttce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .q_push   (push),
        .q_data   (push_data)
    );

    ttce_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    ttce_back #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/ttce_front.sv */
module ttce_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [ttce_pkg::CHAR_W-1:0]         s_tdata,   // [7:0] char_code
    input  logic                                s_tlast,   // end_of_string
    input  ttce_pkg::q_status_t                 q_status,
    output logic                                q_push,
    output ttce_pkg::op_t                       q_data
);

    typedef enum logic [3:0] {
        ESC_IDLE   = 4'b0001,
        ESC_DOLLAR = 4'b0010,
        ESC_FG     = 4'b0100,
        ESC_BG     = 4'b1000
    } esc_state_t;

    esc_state_t                       phase_reg, phase_next;
    logic [ttce_pkg::COLOR_W-1:0]     color_reg, color_next;
    logic [2:0]                       pend_valid_reg, pend_valid_next;
    ttce_pkg::op_t                    pend_op_reg [3];
    ttce_pkg::op_t                    pend_op_next [3];

    logic                             accept;
    logic                             c_hex, c_fb, c_dollar, c_nl, plain_emit, plain_hold;
    logic [2:0]                       new_valid;
    logic [ttce_pkg::CHAR_W-1:0]      glyph1;
    logic                             w0, w1, w2;
    ttce_pkg::op_t                    new_op [3];
    logic [2:0]                       sel_valid, sel_low;
    ttce_pkg::op_t                    sel_op [3];

    assign s_tready = (pend_valid_reg == 3'b000) && !q_status.full;
    assign accept   = s_tvalid && s_tready;

    assign c_hex      = ttce_pkg::is_hex(s_tdata);
    assign c_fb       = (s_tdata == ttce_pkg::CH_FG) || (s_tdata == ttce_pkg::CH_BG);
    assign c_dollar   = (s_tdata == ttce_pkg::CH_DOLLAR);
    assign c_nl       = (s_tdata == ttce_pkg::CH_NEWLINE);
    assign plain_hold = c_dollar && !s_tlast;
    assign plain_emit = !plain_hold;

    // slot 0 is a held '$', slot 1 a held letter, slot 2 the new character
    always_comb
    begin
        new_valid  = 3'b000;
        glyph1     = ttce_pkg::CH_FG;
        phase_next = phase_reg;
        color_next = color_reg;
        case (phase_reg)
            ESC_IDLE:
            begin
                new_valid[2] = plain_emit;
                phase_next   = plain_hold ? ESC_DOLLAR : ESC_IDLE;
            end
            ESC_DOLLAR:
            begin
                if (c_fb && s_tlast)
                begin
                    new_valid[1:0] = 2'b11;
                    glyph1         = s_tdata;
                    phase_next     = ESC_IDLE;
                end
                else if (c_fb)
                begin
                    phase_next = (s_tdata == ttce_pkg::CH_FG) ? ESC_FG : ESC_BG;
                end
                else
                begin
                    new_valid[0] = 1'b1;
                    new_valid[2] = plain_emit;
                    phase_next   = plain_hold ? ESC_DOLLAR : ESC_IDLE;
                end
            end
            ESC_FG, ESC_BG:
            begin
                if (c_hex)
                begin
                    if (phase_reg == ESC_FG)
                    begin
                        color_next = {color_reg[7:4], ttce_pkg::hex_val(s_tdata)};
                    end
                    else
                    begin
                        color_next = {ttce_pkg::hex_val(s_tdata), color_reg[3:0]};
                    end
                    phase_next = ESC_IDLE;
                end
                else
                begin
                    new_valid  = {plain_emit, 2'b11};
                    glyph1     = (phase_reg == ESC_FG) ? ttce_pkg::CH_FG : ttce_pkg::CH_BG;
                    phase_next = plain_hold ? ESC_DOLLAR : ESC_IDLE;
                end
            end
            default:
            begin
                phase_next = ESC_IDLE;
            end
        endcase
    end

    // tlast goes on the final slot that actually writes a cell
    assign w0 = new_valid[0];
    assign w1 = new_valid[1];
    assign w2 = new_valid[2] && !c_nl;

    always_comb
    begin
        new_op[0] = '{glyph: ttce_pkg::CH_DOLLAR, color: color_reg, newline: 1'b0,
                      last: w0 && !w1 && !w2};
        new_op[1] = '{glyph: glyph1, color: color_reg, newline: 1'b0, last: w1 && !w2};
        new_op[2] = '{glyph: s_tdata, color: color_reg, newline: c_nl, last: w2};
    end

    always_comb
    begin
        if (accept)
        begin
            sel_valid = new_valid;
            sel_op    = new_op;
        end
        else
        begin
            sel_valid = pend_valid_reg;
            sel_op    = pend_op_reg;
        end
        sel_low = sel_valid & (~sel_valid + 3'b001);
    end

    assign q_push = (sel_valid != 3'b000) && !q_status.full;

    always_comb
    begin
        q_data = sel_op[2];
        if (sel_low[0])
        begin
            q_data = sel_op[0];
        end
        else if (sel_low[1])
        begin
            q_data = sel_op[1];
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        if (q_push)
        begin
            pend_valid_next = sel_valid & ~sel_low;
            pend_op_next    = sel_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ESC_IDLE;
            color_reg      <= ttce_pkg::COLOR_INIT;
            pend_valid_reg <= 3'b000;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                color_reg <= color_next;
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

endmodule

/* hw/rtl/ttce_fifo.sv */
module ttce_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ttce_pkg::op_t       push_data,
    input  logic                pop,
    output ttce_pkg::op_t       head,
    output ttce_pkg::q_status_t status
);

    ttce_pkg::op_t                  mem_reg [ttce_pkg::QUEUE_DEPTH];
    logic [ttce_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ttce_pkg::QPTR_W:0]      count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (ttce_pkg::QPTR_W+1)'(ttce_pkg::QUEUE_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hw/rtl/ttce_back.sv */
module ttce_back #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ttce_pkg::q_status_t                 q_status,
    input  ttce_pkg::op_t                       q_head,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ttce_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);

    localparam int COL_W   = (SCREEN_COLUMNS > 2) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W   = (SCREEN_ROWS > 2) ? $clog2(SCREEN_ROWS) : 1;
    localparam int CELLS_W = $clog2(SCREEN_ROWS * SCREEN_COLUMNS);
    localparam int BASE_W  = (CELLS_W > ttce_pkg::CELL_INDEX_W) ? CELLS_W
                                                                  : ttce_pkg::CELL_INDEX_W;
    localparam int PAD_W   = ttce_pkg::OUT_DATA_W - ttce_pkg::CELL_INDEX_W
                             - ttce_pkg::CHAR_W - ttce_pkg::COLOR_W;

    logic [COL_W-1:0]                   col_reg, col_next;
    logic [ROW_W-1:0]                   row_reg, row_next;
    logic [BASE_W-1:0]                  base_reg, base_next;
    logic                               valid_reg;
    logic [ttce_pkg::CELL_INDEX_W-1:0]  index_reg;
    logic [ttce_pkg::CHAR_W-1:0]        glyph_reg;
    logic [ttce_pkg::COLOR_W-1:0]       color_reg;
    logic                               last_reg;

    logic                               out_free, load, advance_row;
    logic [BASE_W-1:0]                  cell_sum;

    assign out_free = !valid_reg || m_tready;
    assign q_pop    = !q_status.empty && (q_head.newline || out_free);
    assign load     = q_pop && !q_head.newline;
    assign cell_sum = base_reg + BASE_W'(col_reg);

    assign advance_row = q_head.newline || (col_reg == COL_W'(SCREEN_COLUMNS - 1));

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        if (q_pop)
        begin
            if (advance_row)
            begin
                col_next = '0;
                if (row_reg == ROW_W'(SCREEN_ROWS - 1))
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + BASE_W'(SCREEN_COLUMNS);
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= cell_sum[ttce_pkg::CELL_INDEX_W-1:0];
            glyph_reg <= q_head.glyph;
            color_reg <= q_head.color;
            last_reg  <= q_head.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, color_reg, glyph_reg, index_reg};
    assign m_tlast  = last_reg;

endmodule

/* hw/rtl/ttce_checker.sv */
module ttce_checker #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [ttce_pkg::CHAR_W-1:0]         s_tdata,
    input logic                                s_tlast,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [ttce_pkg::OUT_DATA_W-1:0]     m_tdata,
    input logic                                m_tlast
);

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transaction dropped or changed while stalled");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (32'(m_tdata[ttce_pkg::CELL_INDEX_W-1:0]) < CELLS))
        else $error("cell index outside the screen");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[ttce_pkg::OUT_DATA_W-1:27] == '0))
        else $error("padding bits of output data not zero");

    // nothing is offered on the output in the first cycle out of reset
    a_no_out_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind text_terminal_with_color_escapes ttce_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_ttce_checker (.*);
